// ===== rtl/edd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the error diffusion dither.
package edd_pkg;

  // Configuration register indexes
  localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam int unsigned CFG_W   = 11;
  localparam int unsigned ERR_W   = 16;
  localparam int unsigned LANES   = 3;
  localparam int unsigned STORE_W = ERR_W * LANES;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  // Values in 1/16 LSB: full scale is 255*16
  localparam logic signed [16:0] FULL_SCALE = 17'sd4080;
  localparam logic signed [15:0] THRESHOLD  = 16'sd2040;

  // Diffusion weights, in sixteenths
  localparam logic [2:0] W_RIGHT      = 3'd7;
  localparam logic [2:0] W_BELOW_LEFT = 3'd3;
  localparam logic [2:0] W_BELOW      = 3'd5;
  localparam logic [2:0] W_BELOW_RGT  = 3'd1;

  // Per-lane control from the pixel sequencer
  typedef struct packed {
    logic adv;       // item in the work stage is committed this cycle
    logic has_left;  // column > 0
    logic last_col;  // last pixel of the row
  } lane_ctrl_t;

  // Row and frame markers for the output stage
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } out_flags_t;

  // Clamp to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
    logic signed [15:0] r;
    if (x > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // floor(w*e/16)
  function automatic logic signed [15:0] share(input logic signed [15:0] e,
                                               input logic [2:0] w);
    logic signed [18:0] p;
    p = $signed({{3{e[15]}}, e}) * $signed({16'd0, w});
    return {p[18], p[18:4]};
  endfunction

endpackage

// ===== rtl/edd_row_store.sv =====
// Row error memory: one write port, one registered read port.
module edd_row_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old word on a same-edge write; caller forwards
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/edd_lane.sv =====
// One color channel: threshold, error split and the per-row carry registers.
module edd_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  edd_pkg::lane_ctrl_t     ctrl_i,
  input  logic [7:0]              sample_i,
  input  logic signed [15:0]      below_i,
  output logic                    bit_o,
  output logic signed [15:0]      left_err_o,
  output logic signed [15:0]      tail_err_o
);

  logic signed [15:0] rc_q, rc_d;
  logic signed [15:0] blp_q, blp_d;
  logic signed [15:0] bp_q, bp_d;

  logic signed [17:0] v;
  logic signed [15:0] s1, c, e, blp_new;
  logic signed [16:0] e_wide;
  logic signed [15:0] sh_bl, sh_b, sh_br, sh_r;
  logic               bit_c;

  always_comb begin
    v       = $signed({6'd0, sample_i, 4'd0});
    s1      = edd_pkg::sat16(v + $signed({{2{rc_q[15]}}, rc_q}));
    c       = edd_pkg::sat16($signed({{2{s1[15]}}, s1}) + $signed({{2{below_i[15]}}, below_i}));
    bit_c   = c > edd_pkg::THRESHOLD;
    e_wide  = $signed({c[15], c}) - (bit_c ? edd_pkg::FULL_SCALE : 17'sd0);
    e       = e_wide[15:0];

    sh_bl = edd_pkg::share(e, edd_pkg::W_BELOW_LEFT);
    sh_b  = edd_pkg::share(e, edd_pkg::W_BELOW);
    sh_br = edd_pkg::share(e, edd_pkg::W_BELOW_RGT);
    sh_r  = edd_pkg::share(e, edd_pkg::W_RIGHT);

    // column 0 has no left neighbor in the next row
    left_err_o = ctrl_i.has_left ?
                 edd_pkg::sat16($signed({{2{blp_q[15]}}, blp_q})
                                + $signed({{2{sh_bl[15]}}, sh_bl})) : 16'sd0;
    blp_new = edd_pkg::sat16($signed({{2{bp_q[15]}}, bp_q})
                             + $signed({{2{sh_b[15]}}, sh_b}));

    blp_d = ctrl_i.last_col ? 16'sd0 : blp_new;
    bp_d  = ctrl_i.last_col ? 16'sd0 : sh_br;
    rc_d  = ctrl_i.last_col ? 16'sd0 : sh_r;
  end

  assign bit_o      = bit_c;
  assign tail_err_o = blp_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      blp_q <= '0;
      bp_q  <= '0;
    end else if (ctrl_i.adv) begin
      rc_q  <= rc_d;
      blp_q <= blp_d;
      bp_q  <= bp_d;
    end
  end

endmodule

// ===== rtl/edd_out_merge.sv =====
// Output register: gathers the lane bits and row/frame markers into one result.
module edd_out_merge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   take_i,
  input  logic [2:0]             lane_bits_i,
  input  edd_pkg::out_flags_t    flags_i,
  output logic                   valid_o,
  output logic                   red_bit_o,
  output logic                   green_bit_o,
  output logic                   blue_bit_o,
  output logic                   row_end_o,
  output logic                   frame_end_o
);

  logic                valid_q, valid_d;
  logic [2:0]          bits_q;
  edd_pkg::out_flags_t flags_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bits_q  <= lane_bits_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o     = valid_q;
  assign red_bit_o   = bits_q[0];
  assign green_bit_o = bits_q[1];
  assign blue_bit_o  = bits_q[2];
  assign row_end_o   = flags_q.row_end;
  assign frame_end_o = flags_q.frame_end;

endmodule

// ===== rtl/error_diffusion_dither.sv =====
// Top level of the Floyd-Steinberg error diffusion dither for an RGB stream.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   in      | sink      | in_valid_i / in_stall_o | red_in_i, green_in_i, blue_in_i
//   out     | source    | out_valid_o/out_stall_i | red/green/blue_bit_o, row/frame_end_o
//   cfg     | sink      | cfg_we_i (no wait)     | cfg_index_i, cfg_wdata_i
//
// One pixel per cycle sustained while the output is not stalled; each taken request is
// held in the work stage, then loaded into the output register as it advances. The rate
// is set by each lane's combinational right-carry loop: threshold, error, 7/16 share.
// The row error memory needs no clearing pass: row 0 reads zero and later rows only read
// columns written by the row above unless width grew mid-frame. Reset clears counters
// and carries. A stalled output holds the work stage, which in turn stalls the input.
module error_diffusion_dither #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel requests
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  red_in_i,
  input  logic [7:0]                  green_in_i,
  input  logic [7:0]                  blue_in_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        red_bit_o,
  output logic                        green_bit_o,
  output logic                        blue_bit_o,
  output logic                        row_end_o,
  output logic                        frame_end_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [edd_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // compare widths: hold both the register and the maximum
  localparam int unsigned WW = ($clog2(MAX_WIDTH + 1) > edd_pkg::CFG_W) ?
                               $clog2(MAX_WIDTH + 1) : edd_pkg::CFG_W;
  localparam int unsigned HW = ($clog2(MAX_HEIGHT + 1) > edd_pkg::CFG_W) ?
                               $clog2(MAX_HEIGHT + 1) : edd_pkg::CFG_W;
  localparam int unsigned SW = edd_pkg::STORE_W;
  localparam int unsigned EW = edd_pkg::ERR_W;

  // ---------------- configuration ----------------
  logic [edd_pkg::CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= edd_pkg::CFG_SIZE_RESET;
      height_q <= edd_pkg::CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        edd_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        edd_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective size: 0 acts as 1, above the maximum acts as the maximum
  logic [WW-1:0] width_ext, width_eff;
  logic [HW-1:0] height_ext, height_eff;

  always_comb begin
    width_ext  = WW'(width_q);
    height_ext = HW'(height_q);
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (height_ext == '0) begin
      height_eff = HW'(1);
    end else if (height_ext > HW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = height_ext;
    end
  end

  // ---------------- raster position ----------------
  // Counters step at accept; the request carries its own position flags.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          in_acc;
  logic          last_col, last_row;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign last_col = (WW'(col_q) + WW'(1)) >= width_eff;
  assign last_row = (HW'(row_q) + HW'(1)) >= height_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- work stage ----------------
  logic          a_valid_q;
  logic [CW-1:0] a_col_q;
  logic          a_last_col_q, a_frame_end_q, a_row0_q;
  logic [7:0]    a_red_q, a_green_q, a_blue_q;
  logic          fwd_hit_q;
  logic [SW-1:0] fwd_data_q;
  logic          a_adv;
  logic          out_take;

  assign out_take   = out_valid_o && !out_stall_i;
  assign a_adv      = a_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_adv;

  // pending last-column error, flushed on the next row's first pixel
  logic          tail_valid_q, tail_valid_d;
  logic [CW-1:0] tail_addr_q;
  logic [SW-1:0] tail_data_q;

  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic [SW-1:0] mem_rdata;

  logic [SW-1:0] left_err_all, tail_err_all;
  logic [SW-1:0] below_all;
  logic [2:0]    lane_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_col_q       <= col_q;
      a_last_col_q  <= last_col;
      a_frame_end_q <= last_col && last_row;
      a_row0_q      <= (row_q == '0);
      a_red_q       <= red_in_i;
      a_green_q     <= green_in_i;
      a_blue_q      <= blue_in_i;
      // write on this same edge to the address being read: forward it
      fwd_hit_q     <= mem_we && (mem_waddr == col_q);
      fwd_data_q    <= mem_wdata;
    end
  end

  // memory write: left neighbor on inner columns, else flush the tail
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = a_col_q - CW'(1);
    mem_wdata    = left_err_all;
    tail_valid_d = tail_valid_q;
    if (a_adv) begin
      if (a_col_q != '0) begin
        mem_we = 1'b1;
      end else if (tail_valid_q) begin
        mem_we       = 1'b1;
        mem_waddr    = tail_addr_q;
        mem_wdata    = tail_data_q;
        tail_valid_d = 1'b0;
      end
      if (a_last_col_q) begin
        tail_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_valid_q <= 1'b0;
    end else begin
      tail_valid_q <= tail_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_last_col_q) begin
      tail_addr_q <= a_col_q;
      tail_data_q <= tail_err_all;
    end
  end

  edd_row_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (SW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (mem_rdata)
  );

  // error from the row above: tail is newest, then same-edge forward, then memory
  always_comb begin
    if (a_row0_q) begin
      below_all = '0;
    end else if (tail_valid_q && (tail_addr_q == a_col_q)) begin
      below_all = tail_data_q;
    end else if (fwd_hit_q) begin
      below_all = fwd_data_q;
    end else begin
      below_all = mem_rdata;
    end
  end

  // ---------------- channel lanes ----------------
  edd_pkg::lane_ctrl_t lane_ctrl;
  logic [7:0]          lane_sample [edd_pkg::LANES];

  assign lane_ctrl.adv      = a_adv;
  assign lane_ctrl.has_left = (a_col_q != '0);
  assign lane_ctrl.last_col = a_last_col_q;

  assign lane_sample[0] = a_red_q;
  assign lane_sample[1] = a_green_q;
  assign lane_sample[2] = a_blue_q;

  for (genvar g = 0; g < edd_pkg::LANES; g++) begin : g_lane
    logic signed [EW-1:0] left_err, tail_err;

    edd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .sample_i   (lane_sample[g]),
      .below_i    ($signed(below_all[g*EW +: EW])),
      .bit_o      (lane_bits[g]),
      .left_err_o (left_err),
      .tail_err_o (tail_err)
    );

    assign left_err_all[g*EW +: EW] = left_err;
    assign tail_err_all[g*EW +: EW] = tail_err;
  end

  // ---------------- merge into the output register ----------------
  edd_pkg::out_flags_t a_flags;

  assign a_flags.row_end   = a_last_col_q;
  assign a_flags.frame_end = a_frame_end_q;

  edd_out_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (a_adv),
    .take_i      (out_take),
    .lane_bits_i (lane_bits),
    .flags_i     (a_flags),
    .valid_o     (out_valid_o),
    .red_bit_o   (red_bit_o),
    .green_bit_o (green_bit_o),
    .blue_bit_o  (blue_bit_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

`ifndef NO_ASSERTIONS
  // a pending tail only exists until the next row's first pixel commits
  a_tail_only_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && (a_col_q != '0)) |-> !tail_valid_q)
    else $error("tail pending while an inner column commits");

  a_tail_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_last_col_q) |=> tail_valid_q)
    else $error("last column did not leave a tail");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |=> out_valid_o)
    else $error("committed request missing from output");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked work stage");
`endif

endmodule

// ===== test/tb_error_diffusion_dither.sv =====
// Testbench for error_diffusion_dither: directed and random RGB streams checked against a dither predictor.
`timescale 1ns / 100ps

module tb_error_diffusion_dither;

  localparam int unsigned MAX_W       = 1024;
  localparam int unsigned MAX_H       = 1024;
  localparam int          LEVEL_FULL  = 4080;  // 255 in 1/16 LSB
  localparam int          LEVEL_HALF  = 2040;  // output bit is 1 above this
  localparam int unsigned PART_ITEMS  = 400;   // minimum random requests per idling profile
  localparam int unsigned LONG_HOLD   = 300;   // receiver hold-off, in cycles
  localparam int unsigned STUCK_LIMIT = 3000;  // cycles with no handshake at all
  localparam int unsigned REPORT_CAP  = 100;   // mismatch lines printed at most

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
    logic row_end;
    logic frame_end;
  } dither_bits_t;

  // Dither predictor plus the queue of results still owed by the block.
  // Errors are kept as plain ints in 1/16 LSB, saturated to 16 bits after each sum.
  class dither_scoreboard;
    int unsigned  width_reg;
    int unsigned  height_reg;
    int           err_store [MAX_W][3];  // errors handed to the next row
    bit           stored [MAX_W];        // entry written at least once since reset
    int           right_err [3];
    int           bl_err [3];            // partial sum for column-1 of next row
    int           below_err [3];         // partial sum for this column of next row
    int unsigned  col_cnt;
    int unsigned  row_cnt;
    dither_bits_t owed_q [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  pixels;
    int unsigned  rows_done;
    int unsigned  frames_done;
    int unsigned  size_writes;

    function new();
      width_reg  = MAX_W;
      height_reg = MAX_H;
      foreach (stored[i]) stored[i] = 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
        right_err[ch] = 0;
        bl_err[ch]    = 0;
        below_err[ch] = 0;
      end
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function int sat16(int x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
    endfunction

    // floor(w*e/16): arithmetic shift of a signed product
    function int share(int e, int w);
      return (e * w) >>> 4;
    endfunction

    function int unsigned eff_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    // Largest width that never makes the block read a row entry nobody wrote.
    function int unsigned width_room();
      int unsigned n;
      if (row_cnt == 0) return MAX_W;
      n = col_cnt;
      while (n < MAX_W && stored[n]) n++;
      return (n == 0) ? 1 : n;
    endfunction

    function void write_reg(logic [0:0] idx, int unsigned val);
      size_writes++;
      if (idx == edd_pkg::CFG_IMAGE_WIDTH) width_reg = val & 32'h7FF;
      else height_reg = val & 32'h7FF;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Accepted pixel request: run one diffusion step and queue the result bits.
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [7:0]   samp [3];
      bit           bits [3];
      int unsigned  w;
      int unsigned  h;
      int unsigned  col;
      bit           last_col;
      bit           last_row;
      int           below;
      int           c;
      int           e;
      dither_bits_t res;
      samp[0]  = r;
      samp[1]  = g;
      samp[2]  = b;
      w        = eff_size(width_reg, MAX_W);
      h        = eff_size(height_reg, MAX_H);
      col      = (col_cnt < MAX_W) ? col_cnt : MAX_W - 1;
      last_col = (col_cnt + 1 >= w);
      last_row = (row_cnt + 1 >= h);
      for (int ch = 0; ch < 3; ch++) begin
        below    = (row_cnt == 0) ? 0 : err_store[col][ch];
        c        = sat16(sat16(int'(samp[ch]) * 16 + right_err[ch]) + below);
        bits[ch] = (c > LEVEL_HALF);
        e        = c - (bits[ch] ? LEVEL_FULL : 0);
        if (col > 0) begin
          err_store[col-1][ch] = sat16(bl_err[ch] + share(e, 3));
          stored[col-1] = 1'b1;
        end
        bl_err[ch]    = sat16(below_err[ch] + share(e, 5));
        below_err[ch] = last_col ? 0 : share(e, 1);
        right_err[ch] = last_col ? 0 : share(e, 7);
        if (last_col) begin
          err_store[col][ch] = bl_err[ch];
          stored[col]        = 1'b1;
          bl_err[ch]         = 0;
          below_err[ch]      = 0;
        end
      end
      res.red       = bits[0];
      res.green     = bits[1];
      res.blue      = bits[2];
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      owed_q.push_back(res);
      pixels++;
      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : row_cnt + 1;
        rows_done++;
        if (last_row) frames_done++;
      end else begin
        col_cnt++;
      end
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result %0d %s expected %0b actual %0b",
                   $time, checked, name, want, got);
      end
    endfunction

    function void check_result(dither_bits_t got);
      dither_bits_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual %b", $time, got);
        return;
      end
      want = owed_q.pop_front();
      compare_field("red_bit", want.red, got.red);
      compare_field("green_bit", want.green, got.green);
      compare_field("blue_bit", want.blue, got.blue);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("frame_end", want.frame_end, got.frame_end);
      checked++;
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals; every block input starts at a known value
  // ---------------------------------------------------------------------------
  logic                      clk;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic [7:0]                red_in      = 8'd0;
  logic [7:0]                green_in    = 8'd0;
  logic [7:0]                blue_in     = 8'd0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic                      red_bit;
  logic                      green_bit;
  logic                      blue_bit;
  logic                      row_end;
  logic                      frame_end;
  logic                      cfg_we      = 1'b0;
  logic [0:0]                cfg_index   = edd_pkg::CFG_IMAGE_WIDTH;
  logic [edd_pkg::CFG_W-1:0] cfg_data    = '0;

  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 73;
  logic        long_hold_req = 1'b0;  // raised once by the stimulus
  bit          hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned stuck_cycles  = 0;

  dither_scoreboard sb = new();

  error_diffusion_dither #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .red_bit_o   (red_bit),
    .green_bit_o (green_bit),
    .blue_bit_o  (blue_bit),
    .row_end_o   (row_end),
    .frame_end_o (frame_end),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: both handshakes sampled at the edge. The result side is checked
  // first; a result can never belong to a request taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result('{red_bit, green_bit, blue_bit, row_end, frame_end});
      if (in_valid && !in_stall)
        sb.note_pixel(red_in, green_in, blue_in);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: random stall, plus one long hold-off counted here so the block
  // backs up and pushes the stall onto its input.
  always @(posedge clk) begin
    if (long_hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: no request moving on either side for too long ends the run.
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
    $display("tb_error_diffusion_dither: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks. Each task starts right after the clock rises.
  // ---------------------------------------------------------------------------

  // Offer one pixel request, maybe after a random gap; returns at the edge
  // where it was taken. Valid stays high into the next request unless a gap follows.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender pause: let every owed result come out, then a short settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Size writes, only while idle. A width that would make a later row read a
  // never-written entry of the row store is cut back to what is safe.
  task automatic set_size(input int unsigned w, input int unsigned h,
                          input bit do_w, input bit do_h);
    int unsigned room;
    if (do_w) begin
      room = sb.width_room();
      if (sb.eff_size(w, MAX_W) > room) w = room;
      cfg_we    <= 1'b1;
      cfg_index <= edd_pkg::CFG_IMAGE_WIDTH;
      cfg_data  <= w[edd_pkg::CFG_W-1:0];
      @(posedge clk);
      sb.write_reg(edd_pkg::CFG_IMAGE_WIDTH, w);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= edd_pkg::CFG_IMAGE_HEIGHT;
      cfg_data  <= h[edd_pkg::CFG_W-1:0];
      @(posedge clk);
      sb.write_reg(edd_pkg::CFG_IMAGE_HEIGHT, h);
    end
    cfg_we <= 1'b0;
  endtask

  // Sample values: extremes, the band around the threshold, and plain random.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] fixed_level(int unsigned k);
    case (k % 8)
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd1;
      5:       return 8'd254;
      6:       return 8'd64;
      default: return 8'd200;
    endcase
  endfunction

  // Mostly narrow images so rows and frames close often; now and then the
  // zero and over-range register values and widths up to the full row store.
  function automatic int unsigned pick_width();
    case ($urandom_range(19))
      0:          return 0;
      1:          return 1;
      2:          return $urandom_range(1024, 2047);
      3:          return $urandom_range(65, 1023);
      4, 5, 6, 7: return $urandom_range(17, 64);
      default:    return $urandom_range(2, 16);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(19))
      0:          return 0;
      1:          return 1;
      2:          return $urandom_range(1024, 2047);
      3, 4, 5, 6: return $urandom_range(5, 16);
      default:    return $urandom_range(2, 4);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned sel;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a few pixels at the reset size (row 0, nothing read back),
    // then a shrink to 4x3 mid-row so the current column becomes the last.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd127, 8'd255);
    drain_results();
    set_size(4, 3, 1'b1, 1'b1);
    // 13 pixels: closes row 0, runs rows 1 and 2 of the 4x3 frame, wraps and runs row 0 again
    for (int i = 0; i < 13; i++)
      send_pixel(fixed_level(i), fixed_level(i + 3), fixed_level(i + 5));
    drain_results();
    // Zero size acts as 1x1: every pixel ends a frame
    set_size(0, 0, 1'b1, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd127, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd128, 8'd255);
    drain_results();
    // Over-range values clamp to the largest size
    set_size(2047, 2047, 1'b1, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd127, 8'd255);
    send_pixel(8'd128, 8'd0, 8'd1);
    drain_results();

    // Random: three idling profiles, each a run of phases. Every phase may
    // resize (often mid-frame) and ends with the sender waiting for all results.
    for (int part = 0; part < 3; part++) begin
      case (part)
        0: begin send_idle_pct = 13; recv_idle_pct = 73; end
        1: begin send_idle_pct = 73; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < PART_ITEMS) begin
        sel = $urandom_range(3);
        set_size(pick_width(), pick_height(), sel != 2, sel != 1);
        // back-to-back requests against a long output hold-off
        if (part == 2 && sent == 0) long_hold_req <= 1'b1;
        burst = $urandom_range(30, 110);
        for (int i = 0; i < burst; i++)
          send_pixel(rand_level(), rand_level(), rand_level());
        sent += burst;
        drain_results();
      end
    end

    // Everything taken; wait out the last results plus the pipeline depth.
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d pixel requests over %0d size writes: %0d rows and %0d frames closed.",
             sb.pixels, sb.size_writes, sb.rows_done, sb.frames_done);
    $display("Results checked: %0d, mismatching fields: %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb_error_diffusion_dither: PASS");
    else
      $display("tb_error_diffusion_dither: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/edd_pkg.sv
rtl/edd_row_store.sv
rtl/edd_lane.sv
rtl/edd_out_merge.sv
rtl/error_diffusion_dither.sv
test/tb_error_diffusion_dither.sv
